// File: rtl/v3alu_pkg.sv
package v3alu_pkg;

   typedef enum logic [2:0] {
      OP_MAG   = 3'd0,
      OP_SCALE = 3'd1,
      OP_ADD   = 3'd2,
      OP_DOT   = 3'd3,
      OP_CROSS = 3'd4,
      OP_PROJ  = 3'd5,
      OP_AREA  = 3'd6,
      OP_BAD   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DIV0 = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      op_type op;
      logic   use_root;
      logic   use_div;
   } cls_type;

   typedef struct packed {
      cls_type           cls;
      logic [2:0][15:0]  a;
      logic [2:0][15:0]  b;
      logic [15:0]       sc;
   } cmd_type;

endpackage

// File: rtl/v3alu_front.sv
module v3alu_front import v3alu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,
   input  logic [2:0]    req_tuser,
   input  logic          q_full,
   output logic          q_push,
   output cmd_type       q_cmd
);

   logic    front_v_ff, front_v_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   assign req_tready = !front_v_ff || !q_full;
   assign take       = req_tvalid && req_tready;
   assign q_push     = front_v_ff && !q_full;
   assign q_cmd      = cmd_ff;

   always_comb begin
      cmd_in.cls.op       = op_type'(req_tuser);
      cmd_in.cls.use_root = 1'b0;
      cmd_in.cls.use_div  = 1'b0;
      unique case (cmd_in.cls.op)
         OP_MAG, OP_AREA: cmd_in.cls.use_root = 1'b1;
         OP_PROJ:         cmd_in.cls.use_div  = 1'b1;
         default: begin
         end
      endcase
      cmd_in.a[0] = req_tdata[15:0];
      cmd_in.a[1] = req_tdata[31:16];
      cmd_in.a[2] = req_tdata[47:32];
      cmd_in.b[0] = req_tdata[63:48];
      cmd_in.b[1] = req_tdata[79:64];
      cmd_in.b[2] = req_tdata[95:80];
      cmd_in.sc   = req_tdata[111:96];
   end

   always_comb begin
      front_v_in = front_v_ff;
      if (take) begin
         front_v_in = 1'b1;
      end else if (q_push) begin
         front_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else begin
         front_v_ff <= front_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// File: rtl/v3alu_queue.sv
module v3alu_queue import v3alu_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head_cmd
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   assign full     = cnt_ff == CW'(DEPTH);
   assign valid    = cnt_ff != '0;
   assign head_cmd = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("item written into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> valid)
      else $error("item taken from empty queue");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == $past(cnt_ff) + CW'($past(push)) - CW'($past(pop)))
      else $error("queue count out of step");

endmodule

// File: rtl/v3alu_back.sv
module v3alu_back import v3alu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  cmd_type       q_cmd,
   output logic          q_pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [159:0]  rsp_tdata,
   output logic [1:0]    rsp_tuser
);

   localparam int STEPS = 32;

   logic en;

   // stage 1: products
   logic                s1_v_ff;
   cls_type             s1_cls_ff;
   logic signed [31:0]  m1_ff [3], m1_in [3];
   logic signed [31:0]  bb1_ff [3], bb1_in [3];
   logic signed [31:0]  xp1_ff [6], xp1_in [6];
   logic signed [16:0]  sum1_ff [3], sum1_in [3];
   logic signed [15:0]  b1_ff [3];
   logic [15:0]         sel_w [3];

   // stage 2: sums, cross parts
   logic                s2_v_ff;
   cls_type             s2_cls_ff;
   logic signed [33:0]  sum2_ff, sum2_in;
   logic [31:0]         n2_ff, n2_in;
   logic signed [32:0]  c2_ff [3], c2_in [3];
   logic signed [39:0]  vec2_ff [3], vec2_in [3];
   logic signed [15:0]  b2_ff [3];

   // stage 3: squares, projection numerators
   logic                s3_v_ff;
   cls_type             s3_cls_ff;
   logic [31:0]         sum3_ff;
   logic [31:0]         n3_ff;
   logic [63:0]         csq3_ff [3], csq3_in [3];
   logic [57:0]         num3_ff [3];
   logic signed [39:0]  vec3_ff [3];
   logic signed [39:0]  scal3_ff, scal3_in;
   logic [32:0]         cneg_w [3];
   logic [31:0]         cabs_w [3];
   logic signed [49:0]  prod_w [3];

   // iteration stages, index 0 loaded from stage 3
   logic                it_v_ff    [0:STEPS];
   cls_type             it_cls_ff  [0:STEPS];
   status_type          it_st_ff   [0:STEPS];
   logic [63:0]         it_arg_ff  [0:STEPS];
   logic [31:0]         it_root_ff [0:STEPS];
   logic [34:0]         it_rrem_ff [0:STEPS];
   logic [31:0]         it_n_ff    [0:STEPS];
   logic [31:0]         it_drem_ff [0:STEPS][3];
   logic [31:0]         it_dq_ff   [0:STEPS][3];
   logic                it_dsg_ff  [0:STEPS][3];
   logic signed [39:0]  it_vec_ff  [0:STEPS][3];
   logic signed [39:0]  it_scal_ff [0:STEPS];

   logic [63:0]         arg0_in;
   status_type          st0_in;
   logic [57:0]         mag_w [3];

   logic [34:0]         rr_w    [STEPS];
   logic [34:0]         trial_w [STEPS];
   logic                rge_w   [STEPS];
   logic [32:0]         dr_w    [STEPS][3];
   logic                dge_w   [STEPS][3];
   logic [32:0]         dsub_w  [STEPS][3];

   // output register
   logic                out_v_ff;
   logic signed [39:0]  out_r_ff [3], out_r_in [3];
   logic signed [39:0]  out_s_ff, out_s_in;
   status_type          out_st_ff;

   assign en    = !out_v_ff || rsp_tready;
   assign q_pop = en && q_valid;

   // stage 1
   always_comb begin
      for (int t = 0; t < 3; t++) begin
         unique case (q_cmd.cls.op)
            OP_MAG:   sel_w[t] = q_cmd.a[t];
            OP_SCALE: sel_w[t] = q_cmd.sc;
            default:  sel_w[t] = q_cmd.b[t];
         endcase
         m1_in[t]   = $signed(q_cmd.a[t]) * $signed(sel_w[t]);
         bb1_in[t]  = $signed(q_cmd.b[t]) * $signed(q_cmd.b[t]);
         sum1_in[t] = $signed({q_cmd.a[t][15], q_cmd.a[t]})
                    + $signed({q_cmd.b[t][15], q_cmd.b[t]});
      end
      xp1_in[0] = $signed(q_cmd.a[1]) * $signed(q_cmd.b[2]);
      xp1_in[1] = $signed(q_cmd.a[2]) * $signed(q_cmd.b[1]);
      xp1_in[2] = $signed(q_cmd.a[2]) * $signed(q_cmd.b[0]);
      xp1_in[3] = $signed(q_cmd.a[0]) * $signed(q_cmd.b[2]);
      xp1_in[4] = $signed(q_cmd.a[0]) * $signed(q_cmd.b[1]);
      xp1_in[5] = $signed(q_cmd.a[1]) * $signed(q_cmd.b[0]);
   end

   // stage 2
   always_comb begin
      sum2_in = 34'(m1_ff[0]) + 34'(m1_ff[1]) + 34'(m1_ff[2]);
      n2_in   = 32'($unsigned(bb1_ff[0])) + 32'($unsigned(bb1_ff[1]))
              + 32'($unsigned(bb1_ff[2]));
      c2_in[0] = 33'(xp1_ff[0]) - 33'(xp1_ff[1]);
      c2_in[1] = 33'(xp1_ff[2]) - 33'(xp1_ff[3]);
      c2_in[2] = 33'(xp1_ff[4]) - 33'(xp1_ff[5]);
      for (int t = 0; t < 3; t++) begin
         unique case (s1_cls_ff.op)
            OP_SCALE: vec2_in[t] = 40'(m1_ff[t]);
            OP_ADD:   vec2_in[t] = {{15{sum1_ff[t][16]}}, sum1_ff[t], 8'h00};
            OP_CROSS: vec2_in[t] = 40'(c2_in[t]);
            default:  vec2_in[t] = '0;
         endcase
      end
   end

   // stage 3
   always_comb begin
      for (int t = 0; t < 3; t++) begin
         cneg_w[t]  = 33'(0) - c2_ff[t];
         cabs_w[t]  = c2_ff[t][32] ? cneg_w[t][31:0] : c2_ff[t][31:0];
         csq3_in[t] = 64'(cabs_w[t]) * 64'(cabs_w[t]);
         prod_w[t]  = b2_ff[t] * sum2_ff;
      end
      scal3_in = (s2_cls_ff.op == OP_DOT) ? 40'(sum2_ff) : '0;
   end

   // load of the iteration pipe
   always_comb begin
      if (s3_cls_ff.op == OP_MAG) begin
         arg0_in = {16'h0000, sum3_ff, 16'h0000};
      end else begin
         arg0_in = csq3_ff[0] + csq3_ff[1] + csq3_ff[2];
      end
      priority if (s3_cls_ff.op == OP_BAD) begin
         st0_in = ST_BAD;
      end else if (s3_cls_ff.use_div && n3_ff == '0) begin
         st0_in = ST_DIV0;
      end else begin
         st0_in = ST_OK;
      end
      for (int t = 0; t < 3; t++) begin
         mag_w[t] = num3_ff[t][57] ? (~num3_ff[t] + 58'd1) : num3_ff[t];
      end
   end

   // one root bit and one quotient bit per lane in each stage
   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         rr_w[k]    = {it_rrem_ff[k][32:0], it_arg_ff[k][63:62]};
         trial_w[k] = {1'b0, it_root_ff[k], 2'b01};
         rge_w[k]   = rr_w[k] >= trial_w[k];
         for (int t = 0; t < 3; t++) begin
            dr_w[k][t]   = {it_drem_ff[k][t], it_dq_ff[k][t][31]};
            dge_w[k][t]  = dr_w[k][t] >= {1'b0, it_n_ff[k]};
            dsub_w[k][t] = dr_w[k][t] - {1'b0, it_n_ff[k]};
         end
      end
   end

   // result select
   always_comb begin
      for (int t = 0; t < 3; t++) begin
         if (it_st_ff[STEPS] != ST_OK) begin
            out_r_in[t] = '0;
         end else if (it_cls_ff[STEPS].use_div) begin
            out_r_in[t] = it_dsg_ff[STEPS][t] ? -40'(it_dq_ff[STEPS][t])
                                              : 40'(it_dq_ff[STEPS][t]);
         end else begin
            out_r_in[t] = it_vec_ff[STEPS][t];
         end
      end
      if (it_st_ff[STEPS] != ST_OK) begin
         out_s_in = '0;
      end else if (it_cls_ff[STEPS].use_root) begin
         out_s_in = 40'(it_root_ff[STEPS]);
      end else begin
         out_s_in = it_scal_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k <= STEPS; k++) begin
            it_v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         s1_v_ff    <= q_valid;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         it_v_ff[0] <= s3_v_ff;
         for (int k = 0; k < STEPS; k++) begin
            it_v_ff[k+1] <= it_v_ff[k];
         end
         out_v_ff <= it_v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_cls_ff <= q_cmd.cls;
         for (int t = 0; t < 3; t++) begin
            m1_ff[t]   <= m1_in[t];
            bb1_ff[t]  <= bb1_in[t];
            sum1_ff[t] <= sum1_in[t];
            b1_ff[t]   <= $signed(q_cmd.b[t]);
         end
         for (int j = 0; j < 6; j++) begin
            xp1_ff[j] <= xp1_in[j];
         end

         s2_cls_ff <= s1_cls_ff;
         sum2_ff   <= sum2_in;
         n2_ff     <= n2_in;
         for (int t = 0; t < 3; t++) begin
            c2_ff[t]   <= c2_in[t];
            vec2_ff[t] <= vec2_in[t];
            b2_ff[t]   <= b1_ff[t];
         end

         s3_cls_ff <= s2_cls_ff;
         sum3_ff   <= sum2_ff[31:0];
         n3_ff     <= n2_ff;
         scal3_ff  <= scal3_in;
         for (int t = 0; t < 3; t++) begin
            csq3_ff[t] <= csq3_in[t];
            num3_ff[t] <= {prod_w[t], 8'h00};
            vec3_ff[t] <= vec2_ff[t];
         end

         it_cls_ff[0]  <= s3_cls_ff;
         it_st_ff[0]   <= st0_in;
         it_arg_ff[0]  <= arg0_in;
         it_root_ff[0] <= '0;
         it_rrem_ff[0] <= '0;
         it_n_ff[0]    <= n3_ff;
         it_scal_ff[0] <= scal3_ff;
         for (int t = 0; t < 3; t++) begin
            it_drem_ff[0][t] <= {7'b0, mag_w[t][56:32]};
            it_dq_ff[0][t]   <= mag_w[t][31:0];
            it_dsg_ff[0][t]  <= num3_ff[t][57];
            it_vec_ff[0][t]  <= vec3_ff[t];
         end

         for (int k = 0; k < STEPS; k++) begin
            it_cls_ff[k+1]  <= it_cls_ff[k];
            it_st_ff[k+1]   <= it_st_ff[k];
            it_arg_ff[k+1]  <= {it_arg_ff[k][61:0], 2'b00};
            it_root_ff[k+1] <= {it_root_ff[k][30:0], rge_w[k]};
            it_rrem_ff[k+1] <= rge_w[k] ? rr_w[k] - trial_w[k] : rr_w[k];
            it_n_ff[k+1]    <= it_n_ff[k];
            it_scal_ff[k+1] <= it_scal_ff[k];
            for (int t = 0; t < 3; t++) begin
               it_drem_ff[k+1][t] <= dge_w[k][t] ? dsub_w[k][t][31:0]
                                                 : dr_w[k][t][31:0];
               it_dq_ff[k+1][t]   <= {it_dq_ff[k][t][30:0], dge_w[k][t]};
               it_dsg_ff[k+1][t]  <= it_dsg_ff[k][t];
               it_vec_ff[k+1][t]  <= it_vec_ff[k][t];
            end
         end

         for (int t = 0; t < 3; t++) begin
            out_r_ff[t] <= out_r_in[t];
         end
         out_s_ff  <= out_s_in;
         out_st_ff <= it_st_ff[STEPS];
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_s_ff, out_r_ff[2], out_r_ff[1], out_r_ff[0]};
   assign rsp_tuser  = out_st_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_st_ff == ST_BAD |-> rsp_tdata == '0)
      else $error("invalid operation with nonzero result");
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_st_ff == ST_DIV0 |-> rsp_tdata == '0)
      else $error("zero-divisor projection with nonzero result");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

endmodule

// File: rtl/vector3_arithmetic_unit.sv
// Three-component vector ALU on signed Q8.8 operands, Q24.16 results.
// Input channel req_*: one item per handshake; req_tuser holds the operation
// (magnitude, scale, add, dot, cross, projection, area, invalid), req_tdata
// the vectors a and b and the scale factor.
// Result channel rsp_*: one result item per input item, in order; rsp_tdata
// holds the result vector and the scalar result, rsp_tuser the status
// (ok, projection onto zero vector, invalid operation).
// From input handshake to rsp_tvalid an item passes an input register, a
// small queue, three multiply/sum stages, a load stage, 32 stages of a
// pipelined square root and three pipelined dividers (one result bit per
// stage) and the output register; one item per cycle while rsp_tready is high.
// When the receiver holds rsp_tready low the back pipeline holds as a whole;
// the queue keeps taking items until it fills, then req_tready falls.
// Reset empties the queue and all pipeline stages; there is no other state.
module vector3_arithmetic_unit import v3alu_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z, scalar
   input  logic [2:0]    req_tuser,  // func
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [159:0]  rsp_tdata,  // r_x, r_y, r_z, s_out
   output logic [1:0]    rsp_tuser   // status
);

   logic    q_push, q_full, q_pop, q_valid;
   cmd_type push_cmd, head_cmd;

   v3alu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   v3alu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   v3alu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import v3alu_pkg::*;

   typedef struct {
      logic [39:0] rx;
      logic [39:0] ry;
      logic [39:0] rz;
      logic [39:0] sv;
      logic [1:0]  st;
   } vres_type;

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic vres_type vector_result(op_type op, logic [111:0] d);
      longint a[3], b[3], c[3], r[3];
      longint sc, dp, n, s;
      logic [63:0] acc;
      vres_type o;
      for (int t = 0; t < 3; t++) begin
         a[t] = longint'($signed(d[16*t +: 16]));
         b[t] = longint'($signed(d[48 + 16*t +: 16]));
         r[t] = 0;
      end
      sc = longint'($signed(d[96 +: 16]));
      s = 0;
      o.st = ST_OK;
      c[0] = a[1]*b[2] - a[2]*b[1];
      c[1] = a[2]*b[0] - a[0]*b[2];
      c[2] = a[0]*b[1] - a[1]*b[0];
      case (op)
         OP_MAG: begin
            acc = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
            s = longint'(isqrt(acc << 16));
         end
         OP_SCALE: for (int t = 0; t < 3; t++) r[t] = sc * a[t];
         OP_ADD: for (int t = 0; t < 3; t++) r[t] = (a[t] + b[t]) * 256;
         OP_DOT: s = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
         OP_CROSS: for (int t = 0; t < 3; t++) r[t] = c[t];
         OP_AREA: begin
            acc = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
            s = longint'(isqrt(acc));
         end
         OP_PROJ: begin
            dp = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
            n = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
            if (n == 0) o.st = ST_DIV0;
            else for (int t = 0; t < 3; t++) r[t] = (b[t] * dp * 256) / n;
         end
         default: o.st = ST_BAD;
      endcase
      o.rx = r[0][39:0];
      o.ry = r[1][39:0];
      o.rz = r[2][39:0];
      o.sv = s[39:0];
      return o;
   endfunction

   class vector_scoreboard;
      vres_type pending[$];
      int errors = 0;

      function void note_item(op_type op, logic [111:0] d);
         pending.push_back(vector_result(op, d));
      endfunction

      function void check_result(logic [159:0] d, logic [1:0] st);
         vres_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h %0d", $time, d, st);
            return;
         end
         e = pending.pop_front();
         if (d[39:0] !== e.rx) begin
            errors++;
            $display("%0t: r_x expected %h actual %h", $time, e.rx, d[39:0]);
         end
         if (d[79:40] !== e.ry) begin
            errors++;
            $display("%0t: r_y expected %h actual %h", $time, e.ry, d[79:40]);
         end
         if (d[119:80] !== e.rz) begin
            errors++;
            $display("%0t: r_z expected %h actual %h", $time, e.rz, d[119:80]);
         end
         if (d[159:120] !== e.sv) begin
            errors++;
            $display("%0t: s_out expected %h actual %h", $time, e.sv, d[159:120]);
         end
         if (st !== e.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.st, st);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [111:0] req_tdata;
   logic [2:0] req_tuser;
   logic [159:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   vector_scoreboard sb = new();
   longint cycles = 0;
   bit hold_rsp = 0;
   bit stim_done = 0;

   vector3_arithmetic_unit uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_tvalid && req_tready) sb.note_item(op_type'(req_tuser), req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      if (cycles > 400000) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic logic [15:0] pick_part();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3, 4: return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(op_type op, logic [111:0] d);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
      repeat (gap) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(op_type op);
      logic [111:0] d;
      for (int k = 0; k < 7; k++) d[16*k +: 16] = pick_part();
      if (op == OP_PROJ && $urandom_range(0, 7) == 0) d[48 +: 48] = '0;
      send_item(op, d);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_rsp) rsp_tready <= 0;
      else if ($urandom_range(0, 3) == 0) rsp_tready <= ($urandom_range(0, 9) == 0) ? 0 : 1;
      else if ($urandom_range(0, 29) == 0) rsp_tready <= 0;
      else rsp_tready <= 1;
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = OP_MAG;
      rsp_tready = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      for (int o = 0; o < 8; o++) begin
         send_item(op_type'(o), {7{16'h8000}});
         send_item(op_type'(o), {7{16'h7fff}});
      end
      send_item(OP_PROJ, {16'h0100, 48'h0, 16'h0300, 16'h0200, 16'h0100});
      send_item(OP_MAG, '0);
      send_item(OP_AREA, {16'h0, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000});
      wait_drained();

      fork
         begin
            hold_rsp = 1;
            repeat (200) @(negedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 60; i++) send_random(op_type'($urandom_range(0, 7)));
      join
      wait_drained();

      for (int i = 0; i < 1450; i++) begin
         if (i == 700) wait_drained();
         send_random(op_type'(($urandom_range(0, 19) == 0) ? 7 : $urandom_range(0, 6)));
      end
      wait_drained();
      repeat (60) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end
endmodule

// File: sim.f
rtl/v3alu_pkg.sv
rtl/v3alu_front.sv
rtl/v3alu_queue.sv
rtl/v3alu_back.sv
rtl/vector3_arithmetic_unit.sv
test/tb_top.sv
